@@ hw/rtl/uart_pkg.sv @@
// Shared widths, types and defaults for the 8N1 serial transceiver.
package uart_pkg;

	localparam int BYTE_W = 8;
	localparam int CFG_W = 16;

	localparam int DATA_BITS_DEF = 8;
	localparam int TICK_COUNT_WIDTH_DEF = 16;
	localparam int BIT_TICKS_RESET = 104;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CFG_W-1:0] cfg_word_t;

endpackage

@@ hw/rtl/uart_chan_if.sv @@
// Valid/ready channel interfaces for the transceiver: tick input, tick result, configuration.
interface uart_in_if;
	logic valid;
	logic ready;
	logic rx_line;
	logic tx_start;
	uart_pkg::byte_t tx_byte;

	modport source (output valid, output rx_line, output tx_start, output tx_byte, input ready);
	modport sink (input valid, input rx_line, input tx_start, input tx_byte, output ready);
endinterface

interface uart_out_if;
	logic valid;
	logic ready;
	logic tx_line;
	logic tx_busy;
	logic rx_valid;
	uart_pkg::byte_t rx_byte;

	modport source (output valid, output tx_line, output tx_busy, output rx_valid,
		output rx_byte, input ready);
	modport sink (input valid, input tx_line, input tx_busy, input rx_valid,
		input rx_byte, output ready);
endinterface

interface uart_cfg_if;
	logic valid;
	logic ready;
	uart_pkg::cfg_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ hw/rtl/uart_8n1_transceiver.sv @@
// Top level of the 8N1 serial transceiver: tick register, receiver and transmitter, result register.
//
// Usage: every transaction on in_ch is one clock tick of the serial timing. It carries the
// sampled receive line level and an optional transmit request with its byte. For every
// input transaction exactly one result transaction leaves on out_ch, in order: the transmit
// line level, the busy flag, and a received byte with its one-tick valid flag.
// cfg carries bit_ticks (ticks per serial bit, zero disables both directions); write it
// only while no tick is in flight. A write is taken in the cycle it is offered.
// A tick is registered in the tick register on acceptance, and its result is registered in
// the result register when the tick register advances.
// Throughput: one tick per cycle while out_ch is ready; the receiver and transmitter state
// advance in a single pass of logic from the tick register to the result register.
// Reset: both directions go idle, the transmit line reads high and bit_ticks returns to 104.
// Stall: while out_ch holds a result, one more tick may be taken into the tick register;
// after that in_ch.ready drops until the result is taken. No tick is lost or repeated.
module uart_8n1_transceiver #(
	parameter int DATA_BITS = uart_pkg::DATA_BITS_DEF,
	parameter int TICK_COUNT_WIDTH = uart_pkg::TICK_COUNT_WIDTH_DEF
) (
	input logic clk,
	input logic arst_n,
	uart_in_if.sink in_ch,
	uart_out_if.source out_ch,
	uart_cfg_if.sink cfg
);

	localparam int CW = TICK_COUNT_WIDTH;
	localparam int PW = $clog2(DATA_BITS + 3);
	localparam int WIDE_W = 2 * uart_pkg::BYTE_W;
	localparam logic [PW-1:0] PH_IDLE = PW'(0);
	localparam logic [PW-1:0] PH_START = PW'(1);
	localparam logic [PW-1:0] PH_FIRST = PW'(2);
	localparam logic [PW-1:0] PH_STOP = PW'(DATA_BITS + 2);

	// Configuration
	logic [CW-1:0] bit_ticks_q;
	logic [31:0] cfg_wide;

	assign cfg.ready = 1'b1;
	assign cfg_wide = 32'(cfg.data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q <= CW'(uart_pkg::BIT_TICKS_RESET);
		end else if (cfg.valid) begin
			bit_ticks_q <= cfg_wide[CW-1:0];
		end
	end

	// Tick register
	logic valid_s1;
	logic rx_line_s1;
	logic tx_start_s1;
	uart_pkg::byte_t tx_byte_s1;
	logic out_valid_q;
	logic advance;

	assign advance = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			rx_line_s1 <= in_ch.rx_line;
			tx_start_s1 <= in_ch.tx_start;
			tx_byte_s1 <= in_ch.tx_byte;
		end
	end

	// Serial state
	logic [PW-1:0] rx_phase_q, rx_phase_d;
	logic [CW-1:0] rx_cnt_q, rx_cnt_d;
	logic [DATA_BITS-1:0] rx_shift_q, rx_shift_d;
	logic [PW-1:0] tx_phase_q, tx_phase_d;
	logic [CW-1:0] tx_cnt_q, tx_cnt_d;
	logic [DATA_BITS-1:0] tx_shift_q, tx_shift_d;
	logic tx_level_q, tx_level_d;
	logic rx_done_d;
	uart_pkg::byte_t rx_byte_d;

	logic [CW-1:0] rx_target;
	logic rx_step_end;
	logic tx_step_end;
	logic [PW-1:0] rx_pos;
	logic [PW-1:0] tx_next_phase;
	logic [PW-1:0] tx_pos;
	logic [WIDE_W-1:0] rx_shift_wide;

	// Step counters end a step once the count reaches its target
	assign rx_target = (rx_phase_q == PH_START) ? (bit_ticks_q >> 1) : bit_ticks_q;
	assign rx_step_end = rx_cnt_q >= rx_target;
	assign tx_step_end = tx_cnt_q >= bit_ticks_q;
	assign rx_pos = rx_phase_q - PH_FIRST;
	assign tx_next_phase = tx_phase_q + PW'(1);
	assign tx_pos = tx_next_phase - PH_FIRST;
	assign rx_shift_wide = WIDE_W'(rx_shift_q);

	always_comb begin
		rx_phase_d = rx_phase_q;
		rx_cnt_d = rx_cnt_q;
		rx_shift_d = rx_shift_q;
		tx_phase_d = tx_phase_q;
		tx_cnt_d = tx_cnt_q;
		tx_shift_d = tx_shift_q;
		tx_level_d = tx_level_q;
		rx_done_d = 1'b0;
		rx_byte_d = '0;

		if (bit_ticks_q == '0) begin
			// Disabled: drop any frame in progress
			rx_phase_d = PH_IDLE;
			rx_cnt_d = '0;
			tx_phase_d = PH_IDLE;
			tx_cnt_d = '0;
			tx_level_d = 1'b1;
		end else begin
			// Receiver
			if (rx_phase_q == PH_IDLE || rx_phase_q > PH_STOP) begin
				rx_phase_d = PH_IDLE;
				if (!rx_line_s1) begin
					rx_phase_d = PH_START;
					rx_cnt_d = CW'(1);
					rx_shift_d = '0;
				end
			end else begin
				rx_cnt_d = rx_step_end ? CW'(1) : rx_cnt_q + CW'(1);
				if (rx_step_end) begin
					if (rx_phase_q == PH_START) begin
						rx_phase_d = PH_FIRST;
					end else if (rx_phase_q < PH_STOP) begin
						for (int i = 0; i < DATA_BITS; i++) begin
							if (rx_pos == PW'(i)) begin
								rx_shift_d[i] = rx_shift_q[i] | rx_line_s1;
							end
						end
						rx_phase_d = rx_phase_q + PW'(1);
					end else begin
						rx_done_d = 1'b1;
						rx_byte_d = rx_shift_wide[uart_pkg::BYTE_W-1:0];
						rx_phase_d = PH_IDLE;
						rx_cnt_d = '0;
					end
				end
			end

			// Transmitter
			if (tx_phase_q == PH_IDLE || tx_phase_q > PH_STOP) begin
				tx_phase_d = PH_IDLE;
				tx_level_d = 1'b1;
				if (tx_start_s1) begin
					tx_shift_d = DATA_BITS'(tx_byte_s1);
					tx_phase_d = PH_START;
					tx_cnt_d = CW'(1);
					tx_level_d = 1'b0;
				end
			end else begin
				tx_cnt_d = tx_step_end ? CW'(1) : tx_cnt_q + CW'(1);
				if (tx_step_end) begin
					if (tx_phase_q == PH_STOP) begin
						tx_phase_d = PH_IDLE;
						tx_cnt_d = '0;
						tx_level_d = 1'b1;
					end else begin
						tx_phase_d = tx_next_phase;
						tx_level_d = 1'b1;
						for (int i = 0; i < DATA_BITS; i++) begin
							if (tx_next_phase != PH_STOP && tx_pos == PW'(i)) begin
								tx_level_d = tx_shift_q[i];
							end
						end
					end
				end
			end
		end
	end

	// Advance state once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_phase_q <= PH_IDLE;
			rx_cnt_q <= '0;
			rx_shift_q <= '0;
			tx_phase_q <= PH_IDLE;
			tx_cnt_q <= '0;
			tx_shift_q <= '0;
			tx_level_q <= 1'b1;
		end else if (advance) begin
			rx_phase_q <= rx_phase_d;
			rx_cnt_q <= rx_cnt_d;
			rx_shift_q <= rx_shift_d;
			tx_phase_q <= tx_phase_d;
			tx_cnt_q <= tx_cnt_d;
			tx_shift_q <= tx_shift_d;
			tx_level_q <= tx_level_d;
		end
	end

	// Result register
	logic tx_line_q;
	logic tx_busy_q;
	logic rx_valid_q;
	uart_pkg::byte_t rx_byte_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			tx_line_q <= tx_level_d;
			tx_busy_q <= tx_phase_d != PH_IDLE;
			rx_valid_q <= rx_done_d;
			rx_byte_q <= rx_byte_d;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.tx_line = tx_line_q;
	assign out_ch.tx_busy = tx_busy_q;
	assign out_ch.rx_valid = rx_valid_q;
	assign out_ch.rx_byte = rx_byte_q;

	// Checks
	a_rx_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rx_done_d |=> rx_phase_q == PH_IDLE)
		else $error("receiver not idle after delivering a byte");

	a_idle_line_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !tx_busy_q |-> tx_line_q)
		else $error("transmit line low while transmitter idle");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && bit_ticks_q == '0 |=> rx_phase_q == PH_IDLE && tx_phase_q == PH_IDLE)
		else $error("frame kept while disabled");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ch.ready |-> valid_s1 && out_valid_q && !out_ch.ready)
		else $error("input stalled without a full pipeline");

endmodule

@@ tb/sv/uart_8n1_checker.sv @@
// Checker for the 8N1 transceiver: predicts every tick result and compares it on out_ch.
`timescale 1ns / 1ps

module uart_8n1_checker (
	input logic clk,
	input logic arst_n,
	uart_in_if in_mon,
	uart_out_if out_mon,
	uart_cfg_if cfg_mon,
	output int fail_count,
	output int pending_results,
	output int tx_frames_seen,
	output int rx_bytes_seen
);

	localparam int CNT_W = uart_pkg::TICK_COUNT_WIDTH_DEF;

	// serial step codes: idle, start bit, first data bit, stop bit
	localparam logic [3:0] PH_IDLE = 4'd0;
	localparam logic [3:0] PH_START = 4'd1;
	localparam logic [3:0] PH_DATA0 = 4'd2;
	localparam logic [3:0] PH_STOP = 4'(uart_pkg::DATA_BITS_DEF + 2);
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic tx_line;
		logic tx_busy;
		logic rx_valid;
		uart_pkg::byte_t rx_byte;
	} tick_result_t;

	tick_result_t tick_results_q[$];
	tick_result_t want;
	tick_result_t got;
	tick_result_t next_result;
	int result_index;
	int report_count;

	// shadow of the block's state and its bit_ticks register
	uart_pkg::cfg_word_t period_q;
	logic [3:0] rx_ph;
	logic [3:0] tx_ph;
	logic [CNT_W-1:0] rx_cnt;
	logic [CNT_W-1:0] tx_cnt;
	uart_pkg::byte_t rx_sr;
	uart_pkg::byte_t tx_sr;
	logic tx_lvl;

	// advance a step counter: {step ends, new count}
	function automatic logic [CNT_W:0] step_count(
		logic [CNT_W-1:0] cnt, logic [CNT_W-1:0] target);
		if (cnt >= target)
			return {1'b1, CNT_W'(1)};
		return {1'b0, cnt + CNT_W'(1)};
	endfunction

	task automatic predict_tick(input logic rx, input logic start, input uart_pkg::byte_t tx_in,
		output tick_result_t res);
		logic [CNT_W:0] sc;
		res = '0;
		if (period_q == '0) begin
			// disabled: drop both directions
			rx_ph = PH_IDLE;
			rx_cnt = '0;
			tx_ph = PH_IDLE;
			tx_cnt = '0;
			tx_lvl = 1'b1;
		end else begin
			// receiver
			if (rx_ph == PH_IDLE || rx_ph > PH_STOP) begin
				rx_ph = PH_IDLE;
				if (!rx) begin
					rx_ph = PH_START;
					rx_cnt = CNT_W'(1);
					rx_sr = '0;
				end
			end else if (rx_ph == PH_START) begin
				sc = step_count(rx_cnt, period_q >> 1);
				rx_cnt = sc[CNT_W-1:0];
				if (sc[CNT_W])
					rx_ph = PH_DATA0;
			end else if (rx_ph < PH_STOP) begin
				sc = step_count(rx_cnt, period_q);
				rx_cnt = sc[CNT_W-1:0];
				if (sc[CNT_W]) begin
					rx_sr[3'(rx_ph - PH_DATA0)] = rx;
					rx_ph = rx_ph + 4'd1;
				end
			end else begin
				sc = step_count(rx_cnt, period_q);
				rx_cnt = sc[CNT_W-1:0];
				if (sc[CNT_W]) begin
					res.rx_valid = 1'b1;
					res.rx_byte = rx_sr;
					rx_ph = PH_IDLE;
					rx_cnt = '0;
					rx_bytes_seen++;
				end
			end

			// transmitter
			if (tx_ph == PH_IDLE || tx_ph > PH_STOP) begin
				tx_ph = PH_IDLE;
				tx_lvl = 1'b1;
				if (start) begin
					tx_sr = tx_in;
					tx_ph = PH_START;
					tx_cnt = CNT_W'(1);
					tx_lvl = 1'b0;
					tx_frames_seen++;
				end
			end else begin
				sc = step_count(tx_cnt, period_q);
				tx_cnt = sc[CNT_W-1:0];
				if (sc[CNT_W]) begin
					if (tx_ph == PH_STOP) begin
						tx_ph = PH_IDLE;
						tx_cnt = '0;
						tx_lvl = 1'b1;
					end else begin
						tx_ph = tx_ph + 4'd1;
						if (tx_ph == PH_STOP)
							tx_lvl = 1'b1;
						else
							tx_lvl = tx_sr[3'(tx_ph - PH_DATA0)];
					end
				end
			end
		end
		res.tx_line = tx_lvl;
		res.tx_busy = (tx_ph != PH_IDLE);
	endtask

	// count a failure, report only the first few
	task automatic note_failure(input string what, input tick_result_t exp_r,
		input tick_result_t act_r);
		fail_count++;
		if (report_count < REPORT_LIMIT) begin
			report_count++;
			$display("result %0d %s: expected tx_line=%0b tx_busy=%0b rx_valid=%0b rx_byte=%02h,",
				result_index, what, exp_r.tx_line, exp_r.tx_busy, exp_r.rx_valid, exp_r.rx_byte);
			$display("    got tx_line=%0b tx_busy=%0b rx_valid=%0b rx_byte=%02h",
				act_r.tx_line, act_r.tx_busy, act_r.rx_valid, act_r.rx_byte);
		end
	endtask

	// watch all three channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q = uart_pkg::cfg_word_t'(uart_pkg::BIT_TICKS_RESET);
			rx_ph = PH_IDLE;
			rx_cnt = '0;
			rx_sr = '0;
			tx_ph = PH_IDLE;
			tx_cnt = '0;
			tx_sr = '0;
			tx_lvl = 1'b1;
			tick_results_q.delete();
			fail_count = 0;
			pending_results = 0;
			tx_frames_seen = 0;
			rx_bytes_seen = 0;
			result_index = 0;
			report_count = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready)
				period_q = cfg_mon.data;

			// compare the result transaction with the oldest prediction
			if (out_mon.valid && out_mon.ready) begin
				got.tx_line = out_mon.tx_line;
				got.tx_busy = out_mon.tx_busy;
				got.rx_valid = out_mon.rx_valid;
				got.rx_byte = out_mon.rx_byte;
				if (tick_results_q.size() == 0) begin
					note_failure("unexpected", '0, got);
				end else begin
					want = tick_results_q.pop_front();
					if (got.tx_line !== want.tx_line || got.tx_busy !== want.tx_busy ||
						got.rx_valid !== want.rx_valid || got.rx_byte !== want.rx_byte)
						note_failure("mismatch", want, got);
				end
				result_index++;
			end

			// predict the result of each accepted tick
			if (in_mon.valid && in_mon.ready) begin
				predict_tick(in_mon.rx_line, in_mon.tx_start, in_mon.tx_byte, next_result);
				tick_results_q.push_back(next_result);
			end
			pending_results = tick_results_q.size();
		end
	end

endmodule

@@ tb/sv/tb_uart_8n1_transceiver.sv @@
// Top of the 8N1 transceiver testbench: clock, reset, tick stimulus, stalls and verdict.
`timescale 1ns / 1ps

module tb_uart_8n1_transceiver;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int END_WAIT = 20;

	logic clk;
	logic arst_n;
	int fail_count;
	int pending_results;
	int tx_frames_seen;
	int rx_bytes_seen;
	int idle_cycles;
	int ticks_sent;
	int settings_used;
	int cur_period;
	bit gaps_on;
	bit stalls_on;
	bit rx_pattern_q[$];
	int stall_left;
	int k;

	uart_in_if in_ch();
	uart_out_if out_ch();
	uart_cfg_if cfg_ch();

	uart_8n1_transceiver u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	uart_8n1_checker u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_mon(in_ch),
		.out_mon(out_ch),
		.cfg_mon(cfg_ch),
		.fail_count(fail_count),
		.pending_results(pending_results),
		.tx_frames_seen(tx_frames_seen),
		.rx_bytes_seen(rx_bytes_seen)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// stall the result side in random bursts
	initial begin
		out_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stalls_on && stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else if (stalls_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 12) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles, %0d results outstanding",
					WATCHDOG_LIMIT, pending_results);
				$display("Regression FAIL");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// offer one tick, with an occasional gap before it
	task automatic send_tick(input logic rx, input logic start, input uart_pkg::byte_t tx_in);
		int gap;
		if (gaps_on && $urandom_range(0, 9) == 0) begin
			in_ch.valid <= 1'b0;
			gap = $urandom_range(1, 12);
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_line <= rx;
		in_ch.tx_start <= start;
		in_ch.tx_byte <= tx_in;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic drop_input();
		in_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		wait (pending_results == 0);
		@(negedge clk);
	endtask

	// write bit_ticks once nothing is in flight
	task automatic write_period(input int period);
		drop_input();
		wait_drained();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= uart_pkg::cfg_word_t'(period);
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		cur_period = period;
		settings_used++;
	endtask

	// queue receive line levels: mostly whole frames, some broken frames, idle and noise
	task automatic refill_rx_pattern();
		int bt;
		int kind;
		int n;
		uart_pkg::byte_t data;
		bit level;
		bt = (cur_period == 0) ? 2 : ((cur_period > 12) ? 12 : cur_period);
		kind = $urandom_range(0, 9);
		data = uart_pkg::byte_t'($urandom);
		if (kind <= 6) begin
			for (int b = 0; b < 10; b++) begin
				for (int j = 0; j < bt; j++) begin
					if (b == 0)
						level = 1'b0;
					else if (b == 9)
						level = (kind != 6);
					else
						level = data[b-1];
					if ($urandom_range(0, 49) == 0)
						level = !level;
					rx_pattern_q.push_back(level);
				end
			end
			n = $urandom_range(0, 2);
			repeat (n) rx_pattern_q.push_back(1'b1);
		end else if (kind == 7) begin
			n = $urandom_range(1, 8);
			repeat (n) rx_pattern_q.push_back(1'b1);
		end else begin
			n = $urandom_range(1, 6);
			repeat (n) rx_pattern_q.push_back(1'($urandom_range(0, 1)));
		end
	endtask

	// run a stretch of random ticks at one bit period, optionally draining midway
	task automatic run_serial_phase(input int period, input int n_ticks, input int pause_at);
		bit rx;
		write_period(period);
		for (int i = 0; i < n_ticks; i++) begin
			if (i == pause_at) begin
				drop_input();
				wait_drained();
			end
			if (rx_pattern_q.size() == 0)
				refill_rx_pattern();
			rx = rx_pattern_q.pop_front();
			send_tick(rx, $urandom_range(0, 5) == 0, uart_pkg::byte_t'($urandom));
		end
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.rx_line = 1'b1;
		in_ch.tx_start = 1'b0;
		in_ch.tx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		idle_cycles = 0;
		ticks_sent = 0;
		settings_used = 0;
		cur_period = uart_pkg::BIT_TICKS_RESET;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		arst_n = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset period: start a frame, begin a reception, request while busy
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'hFF);
		send_tick(1'b1, 1'b1, 8'hFF);

		// disabled: both frames in progress are dropped, requests ignored
		write_period(0);
		send_tick(1'b0, 1'b1, 8'hFF);
		send_tick(1'b1, 1'b1, 8'h00);
		send_tick(1'b0, 1'b0, 8'h00);

		// one-tick period: full frame on rx, requests held through a whole tx frame
		write_period(1);
		for (k = 0; k < 12; k++)
			send_tick((k < 2) ? 1'b0 : ((k < 10) ? 1'(8'hA5 >> (k - 2)) : 1'b1), 1'b1,
				k[0] ? 8'h5A : 8'hC3);

		// random stretches over several periods, extremes included
		run_serial_phase(2, 90, -1);
		run_serial_phase(1, 40, -1);
		run_serial_phase(3, 90, 45);
		run_serial_phase(0, 15, -1);
		run_serial_phase(5, 80, -1);
		run_serial_phase(65535, 20, -1);
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		run_serial_phase(4, 70, -1);

		// drain and let the pipeline settle
		drop_input();
		wait_drained();
		repeat (END_WAIT) @(posedge clk);

		$display("Ran %0d ticks over %0d bit-period writes; %0d frames sent, %0d bytes received.",
			ticks_sent, settings_used, tx_frames_seen, rx_bytes_seen);
		if (fail_count == 0 && pending_results == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
